// ----- hw/rtl/pid_position_controller_defines.svh -----
// Assertion macros shared by the controller's RTL files
`ifndef PID_POSITION_CONTROLLER_DEFINES_SVH
`define PID_POSITION_CONTROLLER_DEFINES_SVH

// check that cond implies prop in the same cycle
`define PIDPC_ASSERT_HOLDS(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("pidpc: assertion failed");

// check that cond implies prop in the next cycle
`define PIDPC_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("pidpc: assertion failed");

`endif

// ----- hw/rtl/pidpc_pkg.sv -----
// Types, widths and register codes of the PID position controller
package pidpc_pkg;

   localparam int POSITION_FRACTION_BITS = 8;
   localparam int GAIN_FRACTION_BITS     = 24;
   localparam int FRAC_BITS              = POSITION_FRACTION_BITS + GAIN_FRACTION_BITS;

   localparam int POS_WIDTH   = 32;
   localparam int ERR_WIDTH   = POS_WIDTH + 1;
   localparam int DERIV_WIDTH = ERR_WIDTH + 1;
   localparam int INTEG_WIDTH = 48;
   localparam int INTEG_SPLIT = 24;
   localparam int GAIN_WIDTH  = 32;
   localparam int BAND_WIDTH  = 31;
   localparam int LIMIT_WIDTH = 7;
   localparam int DRIVE_WIDTH = 8;
   localparam int DATA_WIDTH  = 32;

   localparam int PROD_P_WIDTH  = ERR_WIDTH + GAIN_WIDTH;
   localparam int PROD_IL_WIDTH = INTEG_SPLIT + 1 + GAIN_WIDTH;
   localparam int PROD_IH_WIDTH = INTEG_WIDTH - INTEG_SPLIT + GAIN_WIDTH;
   localparam int PROD_D_WIDTH  = DERIV_WIDTH + GAIN_WIDTH;
   localparam int SUM_WIDTH     = INTEG_WIDTH + GAIN_WIDTH + 2;

   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_INDEX_LSB  = 2;
   localparam int CSR_INDEX_WIDTH = CSR_ADDR_WIDTH - CSR_INDEX_LSB;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_P_GAIN        = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_I_GAIN        = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_D_GAIN        = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INTEGRAL_BAND = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OUTPUT_LIMIT  = 3'd4;

   localparam logic [BAND_WIDTH-1:0]  BAND_RESET  = 31'd6400;
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 7'd127;

   typedef logic signed [POS_WIDTH-1:0]     pos_type;
   typedef logic signed [ERR_WIDTH-1:0]     err_type;
   typedef logic signed [DERIV_WIDTH-1:0]   deriv_type;
   typedef logic signed [INTEG_WIDTH-1:0]   integ_type;
   typedef logic signed [GAIN_WIDTH-1:0]    gain_type;
   typedef logic signed [PROD_P_WIDTH-1:0]  prod_p_type;
   typedef logic signed [PROD_IL_WIDTH-1:0] prod_il_type;
   typedef logic signed [PROD_IH_WIDTH-1:0] prod_ih_type;
   typedef logic signed [PROD_D_WIDTH-1:0]  prod_d_type;
   typedef logic signed [SUM_WIDTH-1:0]     sum_type;
   typedef logic signed [DRIVE_WIDTH-1:0]   drive_type;

   localparam integ_type INTEG_MAX = {1'b0, {(INTEG_WIDTH-1){1'b1}}};
   localparam integ_type INTEG_MIN = {1'b1, {(INTEG_WIDTH-1){1'b0}}};

   typedef struct packed {
      gain_type                p_gain;
      gain_type                i_gain;
      gain_type                d_gain;
      logic [BAND_WIDTH-1:0]   integral_band;
      logic [LIMIT_WIDTH-1:0]  output_limit;
   } cfg_type;

endpackage

// ----- hw/rtl/pid_position_controller.sv -----
// Pipeline: rsp_valid rises after an accepted request passes the request register,
// error/integral register, product register, sum register and result register.
// Throughput: one request per cycle; each stage holds under output backpressure and
// empty stages keep taking requests. Integral/error feedback closes in the error stage.
// Reset: synchronous, active high; clears the pipeline, integral and previous error,
// and loads gains 0, integral band 6400, output limit 127.
module pid_position_controller (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  pidpc_pkg::pos_type                  req_target_position,
   input  pidpc_pkg::pos_type                  req_measured_position,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output pidpc_pkg::drive_type                rsp_drive_value,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [pidpc_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [pidpc_pkg::DATA_WIDTH-1:0]     pwdata,
   output logic [pidpc_pkg::DATA_WIDTH-1:0]     prdata,
   output logic                                pready
);
   import pidpc_pkg::*;

   cfg_type     cfg;
   logic        err_valid;
   logic        err_ready;
   err_type     err;
   integ_type   integ;
   deriv_type   deriv;
   logic        prod_valid;
   logic        prod_ready;
   prod_p_type  prod_p;
   prod_il_type prod_il;
   prod_ih_type prod_ih;
   prod_d_type  prod_d;

   pidpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pidpc_error_stage u_error_stage (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_target_position   (req_target_position),
      .req_measured_position (req_measured_position),
      .cfg                   (cfg),
      .out_valid             (err_valid),
      .out_ready             (err_ready),
      .err                   (err),
      .integ                 (integ),
      .deriv                 (deriv)
   );

   pidpc_product_stage u_product_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (err_valid),
      .in_ready  (err_ready),
      .err       (err),
      .integ     (integ),
      .deriv     (deriv),
      .cfg       (cfg),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .prod_p    (prod_p),
      .prod_il   (prod_il),
      .prod_ih   (prod_ih),
      .prod_d    (prod_d)
   );

   pidpc_drive_stage u_drive_stage (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (prod_valid),
      .in_ready        (prod_ready),
      .prod_p          (prod_p),
      .prod_il         (prod_il),
      .prod_ih         (prod_ih),
      .prod_d          (prod_d),
      .cfg             (cfg),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_drive_value (rsp_drive_value)
   );

endmodule

// ----- hw/rtl/pidpc_csr.sv -----
// Configuration registers behind the APB-style port
module pidpc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [pidpc_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [pidpc_pkg::DATA_WIDTH-1:0]     pwdata,
   output logic [pidpc_pkg::DATA_WIDTH-1:0]     prdata,
   output logic                                pready,
   output pidpc_pkg::cfg_type                   cfg
);
   import pidpc_pkg::*;

   cfg_type                    cfg_ff;
   cfg_type                    cfg_in;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic                       write;

   assign index  = paddr[CSR_ADDR_WIDTH-1:CSR_INDEX_LSB];
   assign write  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         unique case (index)
            CSR_P_GAIN:        cfg_in.p_gain        = pwdata;
            CSR_I_GAIN:        cfg_in.i_gain        = pwdata;
            CSR_D_GAIN:        cfg_in.d_gain        = pwdata;
            CSR_INTEGRAL_BAND: cfg_in.integral_band = pwdata[BAND_WIDTH-1:0];
            CSR_OUTPUT_LIMIT:  cfg_in.output_limit  = pwdata[LIMIT_WIDTH-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         CSR_P_GAIN:        prdata = cfg_ff.p_gain;
         CSR_I_GAIN:        prdata = cfg_ff.i_gain;
         CSR_D_GAIN:        prdata = cfg_ff.d_gain;
         CSR_INTEGRAL_BAND: prdata = DATA_WIDTH'(cfg_ff.integral_band);
         CSR_OUTPUT_LIMIT:  prdata = DATA_WIDTH'(cfg_ff.output_limit);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.p_gain        <= '0;
         cfg_ff.i_gain        <= '0;
         cfg_ff.d_gain        <= '0;
         cfg_ff.integral_band <= BAND_RESET;
         cfg_ff.output_limit  <= LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- hw/rtl/pidpc_error_stage.sv -----
// Request register, error, saturating integral with reset band, derivative
`include "pid_position_controller_defines.svh"

module pidpc_error_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pidpc_pkg::pos_type    req_target_position,
   input  pidpc_pkg::pos_type    req_measured_position,
   input  pidpc_pkg::cfg_type    cfg,
   output logic                  out_valid,
   input  logic                  out_ready,
   output pidpc_pkg::err_type    err,
   output pidpc_pkg::integ_type  integ,
   output pidpc_pkg::deriv_type  deriv
);
   import pidpc_pkg::*;

   logic                      in_valid_ff;
   logic                      in_valid_in;
   pos_type                   target_ff;
   pos_type                   measured_ff;
   logic                      valid_ff;
   logic                      valid_in;
   integ_type                 integral_sum_ff;
   integ_type                 integral_sum_in;
   err_type                   previous_error_ff;
   err_type                   previous_error_in;
   deriv_type                 deriv_ff;
   deriv_type                 deriv_in;
   logic                      advance;
   logic                      take;
   err_type                   err_cur;
   logic [ERR_WIDTH-1:0]      err_mag;
   logic signed [INTEG_WIDTH:0] integ_raw;
   integ_type                 integ_sat;
   logic                      clear_integ;

   assign advance   = !valid_ff || out_ready;
   assign req_ready = !in_valid_ff || advance;
   assign take      = in_valid_ff && advance;

   assign err_cur   = ERR_WIDTH'(target_ff) - ERR_WIDTH'(measured_ff);
   assign err_mag   = err_cur[ERR_WIDTH-1] ? ERR_WIDTH'(-err_cur) : err_cur;
   assign integ_raw = (INTEG_WIDTH+1)'(integral_sum_ff) + (INTEG_WIDTH+1)'(err_cur);

   always_comb begin
      priority if (integ_raw[INTEG_WIDTH] != integ_raw[INTEG_WIDTH-1]) begin
         integ_sat = integ_raw[INTEG_WIDTH] ? INTEG_MIN : INTEG_MAX;
      end else begin
         integ_sat = integ_raw[INTEG_WIDTH-1:0];
      end
   end

   assign clear_integ = (err_cur == '0) || (err_mag >= ERR_WIDTH'(cfg.integral_band));

   assign integral_sum_in   = take ? (clear_integ ? '0 : integ_sat) : integral_sum_ff;
   assign previous_error_in = take ? err_cur : previous_error_ff;
   assign deriv_in          = DERIV_WIDTH'(previous_error_ff) - DERIV_WIDTH'(err_cur);
   assign valid_in          = advance ? in_valid_ff : valid_ff;
   assign in_valid_in       = req_ready ? req_valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         valid_ff          <= 1'b0;
         integral_sum_ff   <= '0;
         previous_error_ff <= '0;
      end else begin
         in_valid_ff       <= in_valid_in;
         valid_ff          <= valid_in;
         integral_sum_ff   <= integral_sum_in;
         previous_error_ff <= previous_error_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         target_ff   <= req_target_position;
         measured_ff <= req_measured_position;
      end
      if (take) begin
         deriv_ff <= deriv_in;
      end
   end

   assign out_valid = valid_ff;
   assign err       = previous_error_ff;
   assign integ     = integral_sum_ff;
   assign deriv     = deriv_ff;

   `PIDPC_ASSERT_NEXT(a_zero_error_clears, clock, reset, take && (err_cur == '0), integral_sum_ff == '0)
   `PIDPC_ASSERT_NEXT(a_band_clears, clock, reset, take && (err_mag >= ERR_WIDTH'(cfg.integral_band)), integral_sum_ff == '0)
   `PIDPC_ASSERT_NEXT(a_stall_holds_state, clock, reset, !take, $stable(integral_sum_ff) && $stable(previous_error_ff))

endmodule

// ----- hw/rtl/pidpc_product_stage.sv -----
// Gain products, integral term split into two partial products
module pidpc_product_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  pidpc_pkg::err_type      err,
   input  pidpc_pkg::integ_type    integ,
   input  pidpc_pkg::deriv_type    deriv,
   input  pidpc_pkg::cfg_type      cfg,
   output logic                    out_valid,
   input  logic                    out_ready,
   output pidpc_pkg::prod_p_type   prod_p,
   output pidpc_pkg::prod_il_type  prod_il,
   output pidpc_pkg::prod_ih_type  prod_ih,
   output pidpc_pkg::prod_d_type   prod_d
);
   import pidpc_pkg::*;

   logic                                     valid_ff;
   logic                                     valid_in;
   prod_p_type                               prod_p_ff;
   prod_p_type                               prod_p_in;
   prod_il_type                              prod_il_ff;
   prod_il_type                              prod_il_in;
   prod_ih_type                              prod_ih_ff;
   prod_ih_type                              prod_ih_in;
   prod_d_type                               prod_d_ff;
   prod_d_type                               prod_d_in;
   logic signed [INTEG_SPLIT:0]              integ_low;
   logic signed [INTEG_WIDTH-INTEG_SPLIT-1:0] integ_high;

   assign in_ready   = !valid_ff || out_ready;
   assign valid_in   = in_ready ? in_valid : valid_ff;

   assign integ_low  = {1'b0, integ[INTEG_SPLIT-1:0]};
   assign integ_high = integ[INTEG_WIDTH-1:INTEG_SPLIT];

   assign prod_p_in  = PROD_P_WIDTH'(err) * PROD_P_WIDTH'(cfg.p_gain);
   assign prod_il_in = PROD_IL_WIDTH'(integ_low) * PROD_IL_WIDTH'(cfg.i_gain);
   assign prod_ih_in = PROD_IH_WIDTH'(integ_high) * PROD_IH_WIDTH'(cfg.i_gain);
   assign prod_d_in  = PROD_D_WIDTH'(deriv) * PROD_D_WIDTH'(cfg.d_gain);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         prod_p_ff  <= prod_p_in;
         prod_il_ff <= prod_il_in;
         prod_ih_ff <= prod_ih_in;
         prod_d_ff  <= prod_d_in;
      end
   end

   assign out_valid = valid_ff;
   assign prod_p    = prod_p_ff;
   assign prod_il   = prod_il_ff;
   assign prod_ih   = prod_ih_ff;
   assign prod_d    = prod_d_ff;

endmodule

// ----- hw/rtl/pidpc_drive_stage.sv -----
// Product sum, truncation toward zero, clamp and result register
`include "pid_position_controller_defines.svh"

module pidpc_drive_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  pidpc_pkg::prod_p_type   prod_p,
   input  pidpc_pkg::prod_il_type  prod_il,
   input  pidpc_pkg::prod_ih_type  prod_ih,
   input  pidpc_pkg::prod_d_type   prod_d,
   input  pidpc_pkg::cfg_type      cfg,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output pidpc_pkg::drive_type    rsp_drive_value
);
   import pidpc_pkg::*;

   localparam sum_type ROUND_BIAS = ~({SUM_WIDTH{1'b1}} << FRAC_BITS);

   logic      sum_valid_ff;
   logic      sum_valid_in;
   sum_type   sum_ff;
   sum_type   sum_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   drive_type drive_ff;
   drive_type drive_in;
   logic      advance;
   sum_type   bias;
   sum_type   biased;
   sum_type   trunc;
   sum_type   limit_wide;
   sum_type   neg_limit_wide;
   drive_type limit_ext;

   assign advance      = !rsp_valid_ff || rsp_ready;
   assign in_ready     = !sum_valid_ff || advance;
   assign sum_valid_in = in_ready ? in_valid : sum_valid_ff;
   assign rsp_valid_in = advance ? sum_valid_ff : rsp_valid_ff;

   assign sum_in = SUM_WIDTH'(prod_p) + SUM_WIDTH'(prod_d) + SUM_WIDTH'(prod_il)
                 + (SUM_WIDTH'(prod_ih) <<< INTEG_SPLIT);

   assign bias           = sum_ff[SUM_WIDTH-1] ? ROUND_BIAS : '0;
   assign biased         = sum_ff + bias;
   assign trunc          = biased >>> FRAC_BITS;
   assign limit_wide     = {{(SUM_WIDTH-LIMIT_WIDTH){1'b0}}, cfg.output_limit};
   assign neg_limit_wide = -limit_wide;
   assign limit_ext      = {1'b0, cfg.output_limit};

   always_comb begin
      priority if (trunc > limit_wide) begin
         drive_in = limit_ext;
      end else if (trunc < neg_limit_wide) begin
         drive_in = -limit_ext;
      end else begin
         drive_in = trunc[DRIVE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_valid_ff <= sum_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         sum_ff <= sum_in;
      end
      if (sum_valid_ff && advance) begin
         drive_ff <= drive_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_value = drive_ff;

   `PIDPC_ASSERT_HOLDS(a_drive_in_limit, clock, reset, rsp_valid_ff, (drive_ff <= limit_ext) && (drive_ff >= -limit_ext))
   `PIDPC_ASSERT_NEXT(a_sign_kept, clock, reset, sum_valid_ff && advance && !sum_ff[SUM_WIDTH-1], drive_ff >= 0)

endmodule

// ----- tb/pid_drive_checker.sv -----
`timescale 1ns / 100ps
// Drive command predictor and response checker for the PID position controller
module pid_drive_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  pidpc_pkg::pos_type                   req_target_position,
   input  pidpc_pkg::pos_type                   req_measured_position,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  pidpc_pkg::drive_type                 rsp_drive_value,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [pidpc_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [pidpc_pkg::DATA_WIDTH-1:0]     pwdata,
   input  logic                                 pready,
   output int                                   outstanding,
   output int                                   mismatch_count
);
   import pidpc_pkg::*;

   typedef logic signed [127:0] wide_type;

   cfg_type   ctrl_cfg;
   integ_type integral_acc;
   err_type   last_error;
   drive_type expected_drive[$];
   int        fails = 0;

   function automatic drive_type compute_drive(pos_type target, pos_type measured);
      wide_type tgt_w, meas_w, err_w, mag_err, band_w, integ_w, prev_w, deriv_w;
      wide_type pg_w, ig_w, dg_w, total, magnitude, limit_w;
      logic     negative;
      tgt_w   = wide_type'(target);
      meas_w  = wide_type'(measured);
      err_w   = tgt_w - meas_w;
      integ_w = wide_type'(integral_acc);
      integ_w = integ_w + err_w;
      if (integ_w > wide_type'(INTEG_MAX)) integ_w = wide_type'(INTEG_MAX);
      if (integ_w < wide_type'(INTEG_MIN)) integ_w = wide_type'(INTEG_MIN);
      mag_err = (err_w < 0) ? -err_w : err_w;
      band_w  = wide_type'(ctrl_cfg.integral_band);
      if (err_w == 0 || mag_err >= band_w) integ_w = '0;
      integral_acc = integ_w[INTEG_WIDTH-1:0];

      prev_w     = wide_type'(last_error);
      deriv_w    = prev_w - err_w;
      last_error = err_w[ERR_WIDTH-1:0];

      pg_w  = wide_type'($signed(ctrl_cfg.p_gain));
      ig_w  = wide_type'($signed(ctrl_cfg.i_gain));
      dg_w  = wide_type'($signed(ctrl_cfg.d_gain));
      total = err_w * pg_w + integ_w * ig_w + deriv_w * dg_w;

      negative  = total < 0;
      magnitude = negative ? -total : total;
      magnitude = magnitude >> FRAC_BITS;
      limit_w   = wide_type'(ctrl_cfg.output_limit);
      if (magnitude > limit_w) magnitude = limit_w;
      if (negative) magnitude = -magnitude;
      return magnitude[DRIVE_WIDTH-1:0];
   endfunction

   always @(posedge clock) begin
      drive_type want;
      if (reset) begin
         ctrl_cfg.p_gain        = '0;
         ctrl_cfg.i_gain        = '0;
         ctrl_cfg.d_gain        = '0;
         ctrl_cfg.integral_band = BAND_RESET;
         ctrl_cfg.output_limit  = LIMIT_RESET;
         integral_acc = '0;
         last_error   = '0;
         expected_drive.delete();
         outstanding <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_ADDR_WIDTH-1:CSR_INDEX_LSB])
               CSR_P_GAIN: begin
                  ctrl_cfg.p_gain = pwdata;
               end
               CSR_I_GAIN: begin
                  ctrl_cfg.i_gain = pwdata;
               end
               CSR_D_GAIN: begin
                  ctrl_cfg.d_gain = pwdata;
               end
               CSR_INTEGRAL_BAND: begin
                  ctrl_cfg.integral_band = pwdata[BAND_WIDTH-1:0];
               end
               CSR_OUTPUT_LIMIT: begin
                  ctrl_cfg.output_limit = pwdata[LIMIT_WIDTH-1:0];
               end
               default: begin
               end
            endcase
         end
         if (req_valid && req_ready)
            expected_drive.push_back(compute_drive(req_target_position, req_measured_position));
         if (rsp_valid && rsp_ready) begin
            if (expected_drive.size() == 0) begin
               fails++;
               $display("%0t: drive_value %0d with no request pending", $time, rsp_drive_value);
            end else begin
               want = expected_drive.pop_front();
               if (rsp_drive_value !== want) begin
                  fails++;
                  $display("%0t: drive_value expected %0d, got %0d",
                           $time, want, rsp_drive_value);
               end
            end
         end
         outstanding    <= expected_drive.size();
         mismatch_count <= fails;
      end
   end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Top of the PID position controller testbench: clock, reset, stimulus and verdict
module testbench;
   import pidpc_pkg::*;

   localparam int     STALL_LIMIT      = 2000;
   localparam int     IDLE_PCT         = 59;
   localparam int     BOTH_PCT         = 28;
   localparam int     RANDOM_PER_PHASE = 160;
   localparam int     RANDOM_PHASES    = 8;
   localparam int     WINDUP_STEPS     = 40;
   localparam longint WINDUP_ERROR     = (longint'(1) << 31) - 2;
   localparam pos_type POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
   localparam pos_type POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   pos_type                   req_target_position = '0;
   pos_type                   req_measured_position = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   drive_type                 rsp_drive_value;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [DATA_WIDTH-1:0]     pwdata = '0;
   logic [DATA_WIDTH-1:0]     prdata;
   logic                      pready;
   int                        outstanding;
   int                        mismatch_count;

   int                        gap_pct = 0;
   int                        stall_pct = 0;
   int                        quiet_cycles = 0;
   logic [BAND_WIDTH-1:0]     band_now = BAND_RESET;

   pid_position_controller dut (.*);
   pid_drive_checker drive_check (.*);

   always #10 clock = ~clock;

   always @(posedge clock) rsp_ready <= ($urandom_range(0, 99) >= stall_pct);

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[pid_position_controller] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_request(input pos_type tgt, input pos_type meas);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_target_position   <= tgt;
      req_measured_position <= meas;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic push_error(input longint err);
      longint  half;
      pos_type tgt, meas;
      half = err >>> 1;
      tgt  = pos_type'(half);
      meas = pos_type'(half - err);
      push_request(tgt, meas);
   endtask

   task automatic wait_for_drives();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [DATA_WIDTH-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_WIDTH'(index) << CSR_INDEX_LSB;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      if (index == CSR_INTEGRAL_BAND) band_now = value[BAND_WIDTH-1:0];
   endtask

   function automatic logic [DATA_WIDTH-1:0] random_gain();
      logic [DATA_WIDTH-1:0] mag;
      mag = $urandom_range(0, 1 << 26);
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return -mag;
         default: return mag;
      endcase
   endfunction

   initial begin
      int      phase, n, idx, mode;
      longint  e, span;
      pos_type base;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      repeat (4) push_request($urandom, $urandom);
      wait_for_drives();

      write_csr(CSR_P_GAIN, 32'h0100_0000);
      write_csr(CSR_I_GAIN, 32'h0010_0000);
      write_csr(CSR_D_GAIN, 32'h0080_0000);
      write_csr(CSR_INTEGRAL_BAND, DATA_WIDTH'(BAND_RESET));
      write_csr(CSR_OUTPUT_LIMIT, 100);
      push_request(POS_MAX, POS_MIN);
      push_request(POS_MIN, POS_MAX);
      push_request(POS_MAX, POS_MAX);
      push_request(POS_MIN, POS_MIN);
      push_request('0, '0);
      repeat (3) push_error(longint'(BAND_RESET) - 1);
      push_error(longint'(BAND_RESET));
      push_error(-longint'(BAND_RESET));
      push_error(-longint'(BAND_RESET) + 1);
      push_error(1);
      push_error(-1);
      push_error(0);
      push_request(32'h5555_5555, 32'hAAAA_AAAA);
      push_request(32'hAAAA_AAAA, 32'h5555_5555);
      wait_for_drives();

      write_csr(CSR_P_GAIN, 32'h7FFF_FFFF);
      write_csr(CSR_I_GAIN, 32'h8000_0000);
      write_csr(CSR_D_GAIN, 32'h8000_0000);
      write_csr(CSR_INTEGRAL_BAND, '0);
      write_csr(CSR_OUTPUT_LIMIT, '0);
      push_request(POS_MAX, POS_MIN);
      push_request(POS_MIN, POS_MAX);
      push_error(longint'(BAND_RESET) - 1);
      wait_for_drives();

      write_csr(CSR_P_GAIN, 32'h8000_0000);
      write_csr(CSR_D_GAIN, 32'h7FFF_FFFF);
      write_csr(CSR_INTEGRAL_BAND, {1'b0, {BAND_WIDTH{1'b1}}});
      write_csr(CSR_OUTPUT_LIMIT, DATA_WIDTH'(LIMIT_RESET));
      push_request(POS_MAX, POS_MIN);
      push_error(-WINDUP_ERROR);
      push_error(WINDUP_ERROR);
      wait_for_drives();

      // wind the integral far up, then back down, under the widest band
      write_csr(CSR_P_GAIN, -32'sd65536);
      write_csr(CSR_I_GAIN, 1);
      write_csr(CSR_D_GAIN, '0);
      push_error(0);
      repeat (WINDUP_STEPS) push_error(WINDUP_ERROR);
      push_error(0);
      repeat (WINDUP_STEPS) push_error(-WINDUP_ERROR);
      wait_for_drives();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_for_drives();
         case (phase % 4)
            0: begin
               gap_pct = 0;
               stall_pct = 0;
            end
            1: begin
               gap_pct = IDLE_PCT;
               stall_pct = 0;
            end
            2: begin
               gap_pct = 0;
               stall_pct = IDLE_PCT;
            end
            default: begin
               gap_pct = BOTH_PCT;
               stall_pct = BOTH_PCT;
            end
         endcase
         write_csr(CSR_P_GAIN, random_gain());
         write_csr(CSR_I_GAIN, random_gain());
         write_csr(CSR_D_GAIN, random_gain());
         case (phase)
            0: write_csr(CSR_INTEGRAL_BAND, $urandom_range(256, 16384));
            1: write_csr(CSR_INTEGRAL_BAND, '0);
            2: write_csr(CSR_INTEGRAL_BAND, {1'b0, {BAND_WIDTH{1'b1}}});
            3: write_csr(CSR_INTEGRAL_BAND, DATA_WIDTH'(BAND_RESET));
            4: write_csr(CSR_INTEGRAL_BAND, $urandom_range(1, 1 << 20));
            5: write_csr(CSR_INTEGRAL_BAND, $urandom);
            default: write_csr(CSR_INTEGRAL_BAND, $urandom_range(256, 65536));
         endcase
         case (phase)
            0: write_csr(CSR_OUTPUT_LIMIT, DATA_WIDTH'(LIMIT_RESET));
            4: write_csr(CSR_OUTPUT_LIMIT, '0);
            5: write_csr(CSR_OUTPUT_LIMIT, 1);
            6: write_csr(CSR_OUTPUT_LIMIT, $urandom);
            default: write_csr(CSR_OUTPUT_LIMIT, $urandom_range(0, LIMIT_RESET));
         endcase
         if (phase == 3) begin
            for (idx = CSR_OUTPUT_LIMIT + 1; idx < 2 ** CSR_INDEX_WIDTH; idx++)
               write_csr(CSR_INDEX_WIDTH'(idx), $urandom);
         end

         for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (phase == 2 && n == RANDOM_PER_PHASE / 2) wait_for_drives();
            mode = $urandom_range(0, 99);
            if (mode < 25) begin
               push_request($urandom, $urandom);
            end else if (mode < 35) begin
               base = $urandom;
               push_request(base, base);
            end else if (mode < 45) begin
               e = longint'(band_now) - longint'($urandom_range(0, 1));
               push_error($urandom_range(0, 1) ? -e : e);
            end else begin
               span = (band_now > (1 << 30)) ? (longint'(1) << 31)
                                            : 2 * longint'(band_now) + 16;
               e    = longint'($urandom_range(0, 32'(span))) - span / 2;
               base = $urandom;
               push_request(base + pos_type'(e), base);
            end
         end
      end

      wait_for_drives();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("[pid_position_controller] OK");
      end else begin
         $display("[pid_position_controller] ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/pidpc_pkg.sv
hw/rtl/pidpc_csr.sv
hw/rtl/pidpc_error_stage.sv
hw/rtl/pidpc_product_stage.sv
hw/rtl/pidpc_drive_stage.sv
hw/rtl/pid_position_controller.sv
tb/pid_drive_checker.sv
tb/testbench.sv
